// ===== rtl/ppcl_pkg.sv =====
// shared constants, codes and address helper for the paged priority code list
package ppcl_pkg;

  localparam int PAGES      = 4;
  localparam int CHANNELS   = 2;
  localparam int PAGE_SLOTS = 6;
  localparam int SLOTS      = PAGES * PAGE_SLOTS;
  localparam int WORDS      = CHANNELS * SLOTS;
  localparam int CODE_W     = 8;
  localparam int ADDR_W     = $clog2(WORDS);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int STEP_W     = $clog2(SLOTS + 2);
  localparam int PAGE_W     = $clog2(PAGES);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_SEND   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STAT_DONE       = 3'd0,
    STAT_PRESENT    = 3'd1,
    STAT_NOT_FOUND  = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_EMPTY_CODE = 3'd4
  } status_e;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic ch,
                                                  input logic [SLOT_W-1:0] idx);
    return ADDR_W'(ch) * ADDR_W'(SLOTS) + ADDR_W'(idx);
  endfunction

endpackage

// ===== rtl/paged_priority_code_list.sv =====
// Paged priority code list: per-channel code lists walked slot by slot by a small sequencer.
// Append, insert and remove that change the list scan it and then rewrite it; refused ones only scan,
// and an empty code or unknown action goes straight to the result; clear all runs the rewrite pass only;
// send page reads a page from the snapshot, taken first on page 0; one slot per cycle on one port.
// One item at a time: the next input is taken once the result sits in the output register.
// Reset (async, active low) empties all lists through per-entry valid bits and zeroes counters.
module paged_priority_code_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                action_i,
  input  logic                      channel_i,
  input  logic [ppcl_pkg::CODE_W-1:0] code_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                status_o,
  output logic                      page_valid_o,
  output logic [1:0]                page_number_o,
  output logic [ppcl_pkg::CODE_W-1:0] entry_one_o,
  output logic [ppcl_pkg::CODE_W-1:0] entry_two_o,
  output logic [ppcl_pkg::CODE_W-1:0] entry_three_o,
  output logic [ppcl_pkg::CODE_W-1:0] entry_four_o,
  output logic [ppcl_pkg::CODE_W-1:0] entry_five_o,
  output logic [ppcl_pkg::CODE_W-1:0] entry_six_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ppcl_pkg::CODE_W-1:0] cfg_data_i
);
  import ppcl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_WRITE  = 7'b0001000,
    ST_COPY   = 7'b0010000,
    ST_PAGE   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;
  logic [PAGE_W-1:0]   send_page_q [CHANNELS];
  logic                out_valid_q;
  logic [CODE_W-1:0]   empty_q;

  logic [2:0]          action_q;
  logic                ch_q;
  logic [CODE_W-1:0]   code_q;
  status_e             status_q;
  logic                page_flag_q;
  logic [PAGE_W-1:0]   sp_q;
  logic [SLOT_W-1:0]   len_q;
  logic                len_found_q;
  logic [SLOT_W-1:0]   k_q;
  logic                k_found_q;
  logic [CODE_W-1:0]   d1_q;
  logic [CODE_W-1:0]   d2_q;
  logic [CODE_W-1:0]   pg_buf_q [PAGE_SLOTS];

  status_e             out_status_q;
  logic                out_page_valid_q;
  logic [1:0]          out_page_number_q;
  logic [CODE_W-1:0]   out_entry_q [PAGE_SLOTS];

  logic [CODE_W-1:0]   live_mem [WORDS];
  logic [WORDS-1:0]    live_vld_q;
  logic [CODE_W-1:0]   live_rd_q;
  logic                live_rd_vld_q;
  logic [CODE_W-1:0]   sh_mem [WORDS];
  logic [WORDS-1:0]    sh_vld_q;
  logic [CODE_W-1:0]   sh_rd_q;
  logic                sh_rd_vld_q;

  logic                in_xfer;
  logic                ch_ok;
  logic                out_load;
  logic                full;
  logic [CODE_W-1:0]   live_val;
  logic [CODE_W-1:0]   sh_val;
  logic [STEP_W-1:0]   j;
  logic [STEP_W-1:0]   len_ext;
  logic [STEP_W-1:0]   k_ext;
  logic [SLOT_W-1:0]   rd_idx;
  logic [SLOT_W-1:0]   pg_off;
  logic [SLOT_W-1:0]   pg_idx;
  logic                live_we;
  logic [ADDR_W-1:0]   live_waddr;
  logic [ADDR_W-1:0]   live_raddr;
  logic [CODE_W-1:0]   wr_val;
  logic                sh_we;
  logic [ADDR_W-1:0]   sh_waddr;
  logic [ADDR_W-1:0]   sh_raddr;
  logic [PAGE_W-1:0]   next_sp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign ch_ok       = (32'(channel_i) < CHANNELS);
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign full        = (len_q == SLOT_W'(SLOTS - 1));

  assign live_val = live_rd_vld_q ? live_rd_q : '0;
  assign sh_val   = sh_rd_vld_q ? sh_rd_q : '0;

  assign j       = step_q - STEP_W'(2);
  assign len_ext = STEP_W'(len_q);
  assign k_ext   = STEP_W'(k_q);
  assign rd_idx  = (step_q < STEP_W'(SLOTS)) ? SLOT_W'(step_q) : '0;
  assign pg_off  = (step_q < STEP_W'(PAGE_SLOTS)) ? SLOT_W'(step_q) : '0;
  assign pg_idx  = SLOT_W'(sp_q) * SLOT_W'(PAGE_SLOTS) + pg_off;

  assign live_we    = (state_q == ST_WRITE) && (step_q >= STEP_W'(2));
  assign live_waddr = slot_addr(ch_q, SLOT_W'(j));
  assign live_raddr = slot_addr(ch_q, rd_idx);
  assign sh_we      = (state_q == ST_COPY) && (step_q != '0);
  assign sh_waddr   = slot_addr(ch_q, SLOT_W'(step_q - STEP_W'(1)));
  assign sh_raddr   = slot_addr(ch_q, pg_idx);

  assign next_sp = ((sp_q == PAGE_W'(PAGES - 1)) || (sh_val == empty_q)) ?
                   '0 : PAGE_W'(sp_q + PAGE_W'(1));

  // new value of slot j during the rewrite pass
  always_comb begin
    wr_val = empty_q;
    case (action_e'(action_q))
      ACT_APPEND: begin
        if (j < len_ext) begin
          wr_val = d1_q;
        end else if (j == len_ext) begin
          wr_val = code_q;
        end
      end
      ACT_INSERT: begin
        if (j == '0) begin
          wr_val = code_q;
        end else if (k_found_q) begin
          wr_val = (j <= k_ext) ? d2_q : d1_q;
        end else if (j <= len_ext) begin
          wr_val = d2_q;
        end
      end
      ACT_REMOVE: begin
        if (j < k_ext) begin
          wr_val = d1_q;
        end else if ((j + STEP_W'(1)) < len_ext) begin
          wr_val = live_val;
        end
      end
      default: wr_val = empty_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (live_we) begin
      live_mem[live_waddr] <= wr_val;
    end
    live_rd_q <= live_mem[live_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sh_we) begin
      sh_mem[sh_waddr] <= live_val;
    end
    sh_rd_q <= sh_mem[sh_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_vld_q    <= '0;
      live_rd_vld_q <= 1'b0;
      sh_vld_q      <= '0;
      sh_rd_vld_q   <= 1'b0;
    end else begin
      if (live_we) begin
        live_vld_q[live_waddr] <= 1'b1;
      end
      if (sh_we) begin
        sh_vld_q[sh_waddr] <= 1'b1;
      end
      live_rd_vld_q <= live_vld_q[live_raddr];
      sh_rd_vld_q   <= sh_vld_q[sh_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      empty_q     <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        send_page_q[c] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        empty_q <= cfg_data_i;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_xfer) begin
            if (!ch_ok || (action_i > ACT_SEND)) begin
              state_q <= ST_FINISH;
            end else if ((action_i <= ACT_REMOVE) && (code_i == empty_q)) begin
              state_q <= ST_FINISH;
            end else if (action_i == ACT_CLEAR) begin
              state_q <= ST_WRITE;
            end else if (action_i == ACT_SEND) begin
              state_q <= (send_page_q[CH_W'(channel_i)] == '0) ? ST_COPY : ST_PAGE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SLOTS - 1)) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          step_q <= '0;
          case (action_e'(action_q))
            ACT_APPEND: state_q <= (k_found_q || full) ? ST_FINISH : ST_WRITE;
            ACT_INSERT: state_q <= (!k_found_q && full) ? ST_FINISH : ST_WRITE;
            ACT_REMOVE: state_q <= k_found_q ? ST_WRITE : ST_FINISH;
            default:    state_q <= ST_FINISH;
          endcase
        end
        ST_WRITE: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SLOTS + 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_COPY: begin
          if (step_q == STEP_W'(SLOTS)) begin
            step_q  <= '0;
            state_q <= ST_PAGE;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_PAGE: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(PAGE_SLOTS)) begin
            send_page_q[CH_W'(ch_q)] <= next_sp;
            state_q                  <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          action_q    <= action_i;
          ch_q        <= channel_i;
          code_q      <= code_i;
          page_flag_q <= 1'b0;
          len_q       <= SLOT_W'(SLOTS - 1);
          len_found_q <= 1'b0;
          k_q         <= '0;
          k_found_q   <= 1'b0;
          sp_q        <= send_page_q[CH_W'(channel_i)];
          status_q    <= (ch_ok && (action_i <= ACT_REMOVE) && (code_i == empty_q)) ?
                         STAT_EMPTY_CODE : STAT_DONE;
        end
      end
      ST_SCAN: begin
        if ((step_q != '0) && !len_found_q) begin
          if (live_val == empty_q) begin
            len_q       <= SLOT_W'(step_q - STEP_W'(1));
            len_found_q <= 1'b1;
          end else if ((live_val == code_q) && !k_found_q) begin
            k_q       <= SLOT_W'(step_q - STEP_W'(1));
            k_found_q <= 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        case (action_e'(action_q))
          ACT_APPEND, ACT_INSERT: begin
            if (k_found_q) begin
              status_q <= STAT_PRESENT;
            end else if (full) begin
              status_q <= STAT_FULL;
            end
          end
          ACT_REMOVE: begin
            if (!k_found_q) begin
              status_q <= STAT_NOT_FOUND;
            end
          end
          default: status_q <= STAT_DONE;
        endcase
      end
      ST_WRITE: begin
        d2_q <= d1_q;
        d1_q <= live_val;
      end
      ST_PAGE: begin
        if (step_q != '0) begin
          for (int i = 0; i < PAGE_SLOTS - 1; i++) begin
            pg_buf_q[i] <= pg_buf_q[i + 1];
          end
          pg_buf_q[PAGE_SLOTS - 1] <= sh_val;
        end
        if (step_q == STEP_W'(PAGE_SLOTS)) begin
          page_flag_q <= 1'b1;
        end
      end
      default: begin
        d1_q <= d1_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q      <= status_q;
      out_page_valid_q  <= page_flag_q;
      out_page_number_q <= page_flag_q ? 2'(sp_q) : 2'b00;
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        out_entry_q[i] <= page_flag_q ? pg_buf_q[i] : '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign page_valid_o  = out_page_valid_q;
  assign page_number_o = out_page_number_q;
  assign entry_one_o   = out_entry_q[0];
  assign entry_two_o   = out_entry_q[1];
  assign entry_three_o = out_entry_q[2];
  assign entry_four_o  = out_entry_q[3];
  assign entry_five_o  = out_entry_q[4];
  assign entry_six_o   = out_entry_q[5];

endmodule
